>>> sv/texture_upload_chunk_planner_defines.svh
// assertion macros for the texture upload chunk planner
`ifndef TEXTURE_UPLOAD_CHUNK_PLANNER_DEFINES_SVH
`define TEXTURE_UPLOAD_CHUNK_PLANNER_DEFINES_SVH

// condition implies consequence in the same cycle
`define TUCP_ASSERT_NOW(label, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error("tucp check failed");

// condition implies consequence in the next cycle
`define TUCP_ASSERT_NEXT(label, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error("tucp check failed");

`endif

>>> sv/tucp_pkg.sv
// shared types, constants and helpers of the texture upload chunk planner
package tucp_pkg;

  localparam int MAX_DIM_LOG2 = 14;
  localparam int MAX_LAYERS   = 2048;
  localparam int DIM_W        = MAX_DIM_LOG2 + 1;
  localparam int CUR_W        = MAX_DIM_LOG2;
  localparam int DIV_STEPS    = 32;
  localparam int CNT_W        = $clog2(DIV_STEPS);

  // register indexes
  localparam logic [2:0] CFG_BYTES_PER_UNIT = 3'd0;
  localparam logic [2:0] CFG_COMPRESSED     = 3'd1;
  localparam logic [2:0] CFG_FULL_WIDTH     = 3'd2;
  localparam logic [2:0] CFG_FULL_HEIGHT    = 3'd3;
  localparam logic [2:0] CFG_FULL_DEPTH     = 3'd4;
  localparam logic [2:0] CFG_LAYER_TOTAL    = 3'd5;
  localparam logic [2:0] CFG_MIP_TOTAL      = 3'd6;

  typedef enum logic [0:0] {
    ALU_MUL = 1'b0,
    ALU_DIV = 1'b1
  } alu_op_t;

  // mul: a times b[15:0]; div: a[31:0] over b
  typedef struct packed {
    logic        start;
    alu_op_t     op;
    logic [63:0] a;
    logic [63:0] b;
  } alu_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] value;
  } alu_rsp_t;

  // level size along one axis, capped and never below one
  function automatic logic [DIM_W-1:0] level_dim(input logic [DIM_W-1:0] full,
                                                 input logic [3:0] mip);
    logic [DIM_W-1:0] cap;
    logic [DIM_W-1:0] v;
    cap = (full > DIM_W'(1 << MAX_DIM_LOG2)) ? DIM_W'(1 << MAX_DIM_LOG2) : full;
    v = cap >> mip;
    return (v == '0) ? DIM_W'(1) : v;
  endfunction

  // texel count or 4x4 block count along one axis
  function automatic logic [DIM_W-1:0] block_dim(input logic [DIM_W-1:0] dim,
                                                 input logic comp);
    logic [DIM_W:0] up;
    up = {1'b0, dim} + (DIM_W+1)'(3);
    return comp ? up[DIM_W:2] : dim;
  endfunction

endpackage

>>> sv/tucp_alu.sv
// shared multi-cycle multiply and divide unit built around one 64-bit adder
module tucp_alu (
  input  logic              clk,
  input  logic              rst_n,
  input  tucp_pkg::alu_req_t req,
  output tucp_pkg::alu_rsp_t rsp
);

  logic                       busy_r;
  tucp_pkg::alu_op_t          op_r;
  logic [63:0]                acc_r;
  logic [63:0]                opa_r;
  logic [31:0]                mlt_r;
  logic [tucp_pkg::CNT_W-1:0] cnt_r;
  logic                       done_r;
  logic [63:0]                res_r;

  logic [63:0] add_x;
  logic [63:0] add_y;
  logic        add_cin;
  logic [64:0] sum;
  logic        qbit;

  // shared adder: add for multiply, trial subtract for divide
  assign add_x   = (op_r == tucp_pkg::ALU_DIV) ? {acc_r[62:0], mlt_r[31]} : acc_r;
  assign add_y   = (op_r == tucp_pkg::ALU_DIV) ? ~opa_r : opa_r;
  assign add_cin = (op_r == tucp_pkg::ALU_DIV);
  assign sum     = {1'b0, add_x} + {1'b0, add_y} + {64'd0, add_cin};
  assign qbit    = sum[64];

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (!busy_r && req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (op_r == tucp_pkg::ALU_MUL) begin
          if (mlt_r == '0) begin
            busy_r <= 1'b0;
            done_r <= 1'b1;
          end
        end else if (cnt_r == tucp_pkg::CNT_W'(tucp_pkg::DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath: one shift-add or one restoring step a cycle
  always_ff @(posedge clk) begin
    if (!busy_r && req.start) begin
      op_r  <= req.op;
      acc_r <= '0;
      cnt_r <= '0;
      if (req.op == tucp_pkg::ALU_MUL) begin
        opa_r <= req.a;
        mlt_r <= {16'd0, req.b[15:0]};
      end else begin
        opa_r <= req.b;
        mlt_r <= req.a[31:0];
      end
    end else if (busy_r) begin
      if (op_r == tucp_pkg::ALU_MUL) begin
        if (mlt_r == '0) begin
          res_r <= acc_r;
        end else begin
          if (mlt_r[0]) begin
            acc_r <= sum[63:0];
          end
          opa_r <= {opa_r[62:0], 1'b0};
          mlt_r <= {1'b0, mlt_r[31:1]};
        end
      end else begin
        acc_r <= qbit ? sum[63:0] : add_x;
        mlt_r <= {mlt_r[30:0], qbit};
        cnt_r <= cnt_r + tucp_pkg::CNT_W'(1);
        if (cnt_r == tucp_pkg::CNT_W'(tucp_pkg::DIV_STEPS - 1)) begin
          res_r <= {32'd0, mlt_r[30:0], qbit};
        end
      end
    end
  end

  assign rsp.done  = done_r;
  assign rsp.value = res_r;

endmodule

>>> sv/texture_upload_chunk_planner.sv
// texture upload chunk planner: one request in, one chunk plan out
// sequence: a partial chunk takes four multiplies, a 32-step divide and a
//   byte multiply on the shared unit; a whole-mip walk adds up to four
//   multiplies per extra mip level; a finished request is answered from idle
// throughput: one request at a time, next accepted once the result is taken
// reset: synchronous active-low rst_n restores register defaults and the cursor
`include "texture_upload_chunk_planner_defines.svh"
module texture_upload_chunk_planner (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [14:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_budget_bytes,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_base_mip,
  output logic [3:0]  out_mip_span,
  output logic [10:0] out_base_layer,
  output logic [11:0] out_layer_span,
  output logic [13:0] out_origin_x,
  output logic [13:0] out_origin_y,
  output logic [13:0] out_origin_z,
  output logic [14:0] out_region_width,
  output logic [14:0] out_region_height,
  output logic [14:0] out_region_depth,
  output logic [31:0] out_chunk_bytes,
  output logic        out_finished
);

  localparam int DW = tucp_pkg::DIM_W;
  localparam int CW = tucp_pkg::CUR_W;

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_LVL_GO   = 7'b0000010,
    S_LVL_WAIT = 7'b0000100,
    S_PLAN     = 7'b0001000,
    S_DIV_WAIT = 7'b0010000,
    S_MUL_WAIT = 7'b0100000,
    S_WALK     = 7'b1000000
  } state_t;

  typedef enum logic [3:0] {
    BR_LAYER = 4'b0001,
    BR_SLICE = 4'b0010,
    BR_ROW   = 4'b0100,
    BR_COL   = 4'b1000
  } branch_t;

  // configuration
  logic [4:0]    bpu_r;
  logic          comp_r;
  logic [DW-1:0] full_w_r;
  logic [DW-1:0] full_h_r;
  logic [DW-1:0] full_d_r;
  logic [11:0]   layer_total_r;
  logic [3:0]    mip_total_r;

  // cursor
  logic [3:0]    cursor_mip_r;
  logic          all_done_r;
  logic [10:0]   cursor_layer_r;
  logic [CW-1:0] cursor_z_r;
  logic [CW-1:0] cursor_y_r;
  logic [CW-1:0] cursor_x_r;

  // sequencer
  state_t        state_r;
  branch_t       br_r;
  logic [31:0]   size_r;
  logic [3:0]    mip_sel_r;
  logic [1:0]    lvl_k_r;
  logic          walk_r;
  logic [18:0]   row_r;
  logic [32:0]   slice_r;
  logic [46:0]   layer_r;
  logic [57:0]   mip_r;
  logic [DW-1:0] tw_r;
  logic [DW-1:0] th_r;
  logic [DW-1:0] td_r;
  logic [46:0]   unit_r;
  logic [DW-1:0] n_r;
  logic [31:0]   total_r;
  logic [3:0]    span_r;
  logic [3:0]    cur_r;
  logic          wdone_r;

  // output word
  logic          out_valid_r;
  logic [3:0]    o_base_mip_r;
  logic [3:0]    o_mip_span_r;
  logic [10:0]   o_base_layer_r;
  logic [11:0]   o_layer_span_r;
  logic [CW-1:0] o_x_r;
  logic [CW-1:0] o_y_r;
  logic [CW-1:0] o_z_r;
  logic [DW-1:0] o_w_r;
  logic [DW-1:0] o_h_r;
  logic [DW-1:0] o_d_r;
  logic [31:0]   o_bytes_r;
  logic          o_fin_r;

  tucp_pkg::alu_req_t alu_req;
  tucp_pkg::alu_rsp_t alu_rsp;

  logic [4:0]    ts_eff;
  logic [11:0]   lt_eff;
  logic [DW-1:0] tw_c;
  logic [DW-1:0] th_c;
  logic [DW-1:0] td_c;
  logic [DW-1:0] bw_c;
  logic [DW-1:0] bh_c;
  logic [63:0]   size64;
  logic          cur_nz;
  logic          whole;
  branch_t       plan_br;
  logic [46:0]   plan_div;
  logic [3:0]    restart_mip;
  logic          in_acc;
  logic          cfg_acc;

  logic [DW-1:0] left;
  logic [DW:0]   left_up;
  logic [DW-1:0] bl;
  logic [DW-1:0] nb;
  logic [DW+1:0] nb4;
  logic [DW-1:0] n_c;
  logic [31:0]   q;
  logic          blocky;

  logic [DW:0]   cx_t;
  logic [DW:0]   cy_t;
  logic [DW:0]   cz_t;
  logic [12:0]   cl_t;
  logic          mip_wrap;

  logic [63:0]   walk_sum;
  logic          walk_go;

  tucp_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (alu_req),
    .rsp   (alu_rsp)
  );

  // effective register values
  assign ts_eff = (bpu_r == '0) ? 5'd1 : ((bpu_r > 5'd16) ? 5'd16 : bpu_r);
  assign lt_eff = (layer_total_r == '0) ? 12'd1 :
                  ((layer_total_r > 12'(tucp_pkg::MAX_LAYERS)) ?
                   12'(tucp_pkg::MAX_LAYERS) : layer_total_r);

  // level sizes of the selected mip
  assign tw_c = tucp_pkg::level_dim(full_w_r, mip_sel_r);
  assign th_c = tucp_pkg::level_dim(full_h_r, mip_sel_r);
  assign td_c = tucp_pkg::level_dim(full_d_r, mip_sel_r);
  assign bw_c = tucp_pkg::block_dim(tw_c, comp_r);
  assign bh_c = tucp_pkg::block_dim(th_c, comp_r);

  assign size64 = {32'd0, size_r};
  assign cur_nz = (cursor_layer_r != '0) || (cursor_z_r != '0) ||
                  (cursor_y_r != '0) || (cursor_x_r != '0);
  assign whole  = !cur_nz && !(size64 < {6'd0, mip_r});

  // pick the coarsest unit that fits from the cursor
  always_comb begin
    plan_br  = BR_COL;
    plan_div = {42'd0, ts_eff};
    if ((cursor_z_r != '0) || (cursor_y_r != '0) || (cursor_x_r != '0) ||
        (size64 < {17'd0, layer_r})) begin
      if ((cursor_y_r != '0) || (cursor_x_r != '0) || (size64 < {31'd0, slice_r})) begin
        if ((cursor_x_r == '0) && !(size64 < {45'd0, row_r})) begin
          plan_br  = BR_ROW;
          plan_div = {28'd0, row_r};
        end
      end else begin
        plan_br  = BR_SLICE;
        plan_div = {14'd0, slice_r};
      end
    end else begin
      plan_br  = BR_LAYER;
      plan_div = layer_r;
    end
  end

  // unit count from the quotient and what is left of the level
  assign q      = alu_rsp.value[31:0];
  assign blocky = comp_r && ((br_r == BR_ROW) || (br_r == BR_COL));
  always_comb begin
    unique case (br_r)
      BR_LAYER: left = DW'(lt_eff) - DW'(cursor_layer_r);
      BR_SLICE: left = td_r - {1'b0, cursor_z_r};
      BR_ROW:   left = th_r - {1'b0, cursor_y_r};
      BR_COL:   left = tw_r - {1'b0, cursor_x_r};
      default:  left = '0;
    endcase
  end
  assign left_up = {1'b0, left} + (DW+1)'(3);
  assign bl      = blocky ? left_up[DW:2] : left;
  assign nb      = ({17'd0, bl} < q) ? bl : q[DW-1:0];
  assign nb4     = {nb, 2'b00};
  assign n_c     = !blocky ? nb : ((nb4 < {2'b00, left}) ? nb4[DW-1:0] : left);

  // cursor advance with carries into row, slice, layer and mip
  always_comb begin
    cx_t = {1'b0, 1'b0, cursor_x_r} + ((br_r == BR_COL) ? {1'b0, n_r} : '0);
    cy_t = {1'b0, 1'b0, cursor_y_r} + ((br_r == BR_ROW) ? {1'b0, n_r} : '0);
    cz_t = {1'b0, 1'b0, cursor_z_r} + ((br_r == BR_SLICE) ? {1'b0, n_r} : '0);
    cl_t = {2'b00, cursor_layer_r} + ((br_r == BR_LAYER) ? n_r[12:0] : '0);
    mip_wrap = 1'b0;
    if (cx_t >= {1'b0, tw_r}) begin
      cx_t = '0;
      cy_t = cy_t + (comp_r ? (DW+1)'(4) : (DW+1)'(1));
    end
    if (cy_t >= {1'b0, th_r}) begin
      cy_t = '0;
      cz_t = cz_t + (DW+1)'(1);
    end
    if (cz_t >= {1'b0, td_r}) begin
      cz_t = '0;
      cl_t = cl_t + 13'd1;
    end
    if (cl_t >= {1'b0, lt_eff}) begin
      cl_t = '0;
      mip_wrap = 1'b1;
    end
  end

  // whole-mip walk
  assign walk_sum = {32'd0, total_r} + {6'd0, mip_r};
  assign walk_go  = !wdone_r && !(walk_sum > size64);

  // shared unit requests
  always_comb begin
    alu_req.start = 1'b0;
    alu_req.op    = tucp_pkg::ALU_MUL;
    alu_req.a     = '0;
    alu_req.b     = '0;
    unique case (state_r)
      S_LVL_GO: begin
        alu_req.start = 1'b1;
        case (lvl_k_r)
          2'd0: begin
            alu_req.a = {59'd0, ts_eff};
            alu_req.b = {49'd0, bw_c};
          end
          2'd1: begin
            alu_req.a = {45'd0, row_r};
            alu_req.b = {49'd0, bh_c};
          end
          2'd2: begin
            alu_req.a = {31'd0, slice_r};
            alu_req.b = {49'd0, td_c};
          end
          default: begin
            alu_req.a = {17'd0, layer_r};
            alu_req.b = {52'd0, lt_eff};
          end
        endcase
      end
      S_PLAN: begin
        alu_req.start = !whole;
        alu_req.op    = tucp_pkg::ALU_DIV;
        alu_req.a     = size64;
        alu_req.b     = {17'd0, plan_div};
      end
      S_DIV_WAIT: begin
        alu_req.start = alu_rsp.done;
        alu_req.a     = {17'd0, unit_r};
        alu_req.b     = {49'd0, nb};
      end
      default: begin
        alu_req.start = 1'b0;
      end
    endcase
  end

  assign in_ready  = (state_r == S_IDLE) && !out_valid_r;
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign restart_mip = ((cfg_index == tucp_pkg::CFG_MIP_TOTAL) ? cfg_data[3:0] : mip_total_r);

  // configuration registers and cursor
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpu_r          <= 5'd4;
      comp_r         <= 1'b0;
      full_w_r       <= DW'(1);
      full_h_r       <= DW'(1);
      full_d_r       <= DW'(1);
      layer_total_r  <= 12'd1;
      mip_total_r    <= 4'd1;
      cursor_mip_r   <= '0;
      all_done_r     <= 1'b0;
      cursor_layer_r <= '0;
      cursor_z_r     <= '0;
      cursor_y_r     <= '0;
      cursor_x_r     <= '0;
    end else if (cfg_acc && (cfg_index != 3'd7)) begin
      case (cfg_index)
        tucp_pkg::CFG_BYTES_PER_UNIT: bpu_r         <= cfg_data[4:0];
        tucp_pkg::CFG_COMPRESSED:     comp_r        <= cfg_data[0];
        tucp_pkg::CFG_FULL_WIDTH:     full_w_r      <= cfg_data;
        tucp_pkg::CFG_FULL_HEIGHT:    full_h_r      <= cfg_data;
        tucp_pkg::CFG_FULL_DEPTH:     full_d_r      <= cfg_data;
        tucp_pkg::CFG_LAYER_TOTAL:    layer_total_r <= cfg_data[11:0];
        default:                      mip_total_r   <= cfg_data[3:0];
      endcase
      cursor_mip_r   <= (restart_mip == '0) ? 4'd0 : restart_mip - 4'd1;
      all_done_r     <= 1'b0;
      cursor_layer_r <= '0;
      cursor_z_r     <= '0;
      cursor_y_r     <= '0;
      cursor_x_r     <= '0;
    end else if ((state_r == S_MUL_WAIT) && alu_rsp.done) begin
      cursor_x_r     <= cx_t[CW-1:0];
      cursor_y_r     <= cy_t[CW-1:0];
      cursor_z_r     <= cz_t[CW-1:0];
      cursor_layer_r <= cl_t[10:0];
      if (mip_wrap) begin
        if (cursor_mip_r == '0) begin
          all_done_r <= 1'b1;
        end else begin
          cursor_mip_r <= cursor_mip_r - 4'd1;
        end
      end
    end else if ((state_r == S_WALK) && !walk_go) begin
      cursor_mip_r <= cur_r;
      all_done_r   <= wdone_r;
    end
  end

  // sequencer control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (all_done_r) begin
              out_valid_r <= 1'b1;
            end else begin
              state_r <= S_LVL_GO;
            end
          end
        end
        S_LVL_GO: state_r <= S_LVL_WAIT;
        S_LVL_WAIT: begin
          if (alu_rsp.done) begin
            if (lvl_k_r != 2'd3) begin
              state_r <= S_LVL_GO;
            end else if (walk_r) begin
              state_r <= S_WALK;
            end else begin
              state_r <= S_PLAN;
            end
          end
        end
        S_PLAN: state_r <= whole ? S_WALK : S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (alu_rsp.done) begin
            state_r <= S_MUL_WAIT;
          end
        end
        S_MUL_WAIT: begin
          if (alu_rsp.done) begin
            state_r     <= S_IDLE;
            out_valid_r <= 1'b1;
          end
        end
        S_WALK: begin
          if (walk_go) begin
            if (cur_r != '0) begin
              state_r <= S_LVL_GO;
            end
          end else begin
            state_r     <= S_IDLE;
            out_valid_r <= 1'b1;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // sequencer datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          size_r    <= in_budget_bytes;
          mip_sel_r <= cursor_mip_r;
          lvl_k_r   <= 2'd0;
          walk_r    <= 1'b0;
          if (all_done_r) begin
            o_base_mip_r   <= '0;
            o_mip_span_r   <= '0;
            o_base_layer_r <= '0;
            o_layer_span_r <= '0;
            o_x_r          <= '0;
            o_y_r          <= '0;
            o_z_r          <= '0;
            o_w_r          <= '0;
            o_h_r          <= '0;
            o_d_r          <= '0;
            o_bytes_r      <= '0;
            o_fin_r        <= 1'b1;
          end
        end
      end
      S_LVL_WAIT: begin
        if (alu_rsp.done) begin
          case (lvl_k_r)
            2'd0:    row_r   <= alu_rsp.value[18:0];
            2'd1:    slice_r <= alu_rsp.value[32:0];
            2'd2:    layer_r <= alu_rsp.value[46:0];
            default: mip_r   <= alu_rsp.value[57:0];
          endcase
          lvl_k_r <= lvl_k_r + 2'd1;
        end
      end
      S_PLAN: begin
        tw_r           <= tw_c;
        th_r           <= th_c;
        td_r           <= td_c;
        br_r           <= plan_br;
        unit_r         <= plan_div;
        total_r        <= '0;
        span_r         <= '0;
        cur_r          <= mip_sel_r;
        wdone_r        <= 1'b0;
        o_base_mip_r   <= mip_sel_r;
        o_mip_span_r   <= 4'd1;
        o_base_layer_r <= cursor_layer_r;
        o_layer_span_r <= 12'd1;
        o_x_r          <= cursor_x_r;
        o_y_r          <= cursor_y_r;
        o_z_r          <= cursor_z_r;
      end
      S_DIV_WAIT: begin
        if (alu_rsp.done) begin
          n_r <= n_c;
        end
      end
      S_MUL_WAIT: begin
        if (alu_rsp.done) begin
          o_bytes_r <= alu_rsp.value[31:0];
          o_fin_r   <= mip_wrap && (cursor_mip_r == '0);
          unique case (br_r)
            BR_LAYER: begin
              o_layer_span_r <= n_r[11:0];
              o_w_r <= tw_r;
              o_h_r <= th_r;
              o_d_r <= td_r;
            end
            BR_SLICE: begin
              o_w_r <= tw_r;
              o_h_r <= th_r;
              o_d_r <= n_r;
            end
            BR_ROW: begin
              o_w_r <= tw_r;
              o_h_r <= n_r;
              o_d_r <= DW'(1);
            end
            BR_COL: begin
              o_w_r <= n_r;
              o_h_r <= comp_r ? DW'(4) : DW'(1);
              o_d_r <= DW'(1);
            end
            default: o_d_r <= DW'(1);
          endcase
        end
      end
      S_WALK: begin
        if (walk_go) begin
          total_r <= walk_sum[31:0];
          span_r  <= span_r + 4'd1;
          if (cur_r == '0) begin
            wdone_r <= 1'b1;
          end else begin
            cur_r     <= cur_r - 4'd1;
            mip_sel_r <= cur_r - 4'd1;
            lvl_k_r   <= 2'd0;
            walk_r    <= 1'b1;
          end
        end else begin
          o_mip_span_r   <= span_r;
          o_layer_span_r <= lt_eff;
          o_w_r          <= tw_r;
          o_h_r          <= th_r;
          o_d_r          <= td_r;
          o_bytes_r      <= total_r;
          o_fin_r        <= wdone_r;
        end
      end
      default: begin
        lvl_k_r <= lvl_k_r;
      end
    endcase
  end

  assign out_valid         = out_valid_r;
  assign out_base_mip      = o_base_mip_r;
  assign out_mip_span      = o_mip_span_r;
  assign out_base_layer    = o_base_layer_r;
  assign out_layer_span    = o_layer_span_r;
  assign out_origin_x      = o_x_r;
  assign out_origin_y      = o_y_r;
  assign out_origin_z      = o_z_r;
  assign out_region_width  = o_w_r;
  assign out_region_height = o_h_r;
  assign out_region_depth  = o_d_r;
  assign out_chunk_bytes   = o_bytes_r;
  assign out_finished      = o_fin_r;

  // checks
  `TUCP_ASSERT_NOW(a_chunk_fits, out_valid_r, o_bytes_r <= size_r)
  `TUCP_ASSERT_NEXT(a_busy_after_accept, in_acc, !in_ready)
  `TUCP_ASSERT_NOW(a_alu_done_expected, alu_rsp.done, (state_r == S_LVL_WAIT) || (state_r == S_DIV_WAIT) || (state_r == S_MUL_WAIT))

endmodule
